// File: sv/rcfb_pkg.sv
// ----------------------------------------------------------------------------
// rcfb_pkg
// Shared constants and controller/datapath types for the remote command
// frame builder.
// ----------------------------------------------------------------------------
package rcfb_pkg;

   localparam int MAX_PAYLOAD_DEF = 31;

   // frame constants
   localparam logic [7:0]  START_DELIM  = 8'h7E;
   localparam logic [7:0]  FRAME_TYPE   = 8'h17;
   localparam logic [7:0]  FRAME_ID     = 8'h01;
   localparam logic [7:0]  BCAST_HI     = 8'hFF;
   localparam logic [7:0]  BCAST_LO     = 8'hFE;
   localparam logic [7:0]  CMD_OPTIONS  = 8'h02;
   localparam logic [15:0] BASE_LEN     = 16'd15;

   // header byte positions
   localparam int POS_START  = 0;
   localparam int POS_LEN_HI = 1;
   localparam int POS_LEN_LO = 2;
   localparam int POS_TYPE   = 3;
   localparam int POS_ID     = 4;
   localparam int POS_MAC0   = 5;
   localparam int POS_BC_HI  = 13;
   localparam int POS_BC_LO  = 14;
   localparam int POS_OPT    = 15;
   localparam int POS_CMD_HI = 16;
   localparam int POS_CMD_LO = 17;
   localparam int HDR_BYTES  = 18;

   typedef struct packed {
      logic accept;   // input word taken this cycle
      logic start;    // last word taken, frame emission begins
      logic load;     // load next frame byte into output register
   } ctrl_cmd_type;

   typedef struct packed {
      logic last_byte;  // current position is the checksum
   } ctrl_status_type;

endpackage

// File: sv/rcfb_intf.sv
// ----------------------------------------------------------------------------
// rcfb_req_if / rcfb_rsp_if
// Valid/ready channels for payload words in and frame bytes out.
// ----------------------------------------------------------------------------
interface rcfb_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  payload_byte;
   logic        has_byte;
   logic        last;
   logic [15:0] at_command;
   logic [63:0] dest_mac;

   modport source (output valid, payload_byte, has_byte, last, at_command, dest_mac,
                   input ready);
   modport sink   (input valid, payload_byte, has_byte, last, at_command, dest_mac,
                   output ready);
endinterface

interface rcfb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_end;
   logic       overflow;

   modport source (output valid, frame_byte, frame_end, overflow, input ready);
   modport sink   (input valid, frame_byte, frame_end, overflow, output ready);
endinterface

// File: sv/rcfb_ram.sv
// ----------------------------------------------------------------------------
// rcfb_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rcfb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]    wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]    rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/rcfb_dp.sv
// ----------------------------------------------------------------------------
// rcfb_dp
// Datapath: payload buffer, header fields, frame byte select, checksum and
// output register.
// ----------------------------------------------------------------------------
module rcfb_dp #(
   parameter int MAX_PAYLOAD = rcfb_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  rcfb_pkg::ctrl_cmd_type  cmd,
   output rcfb_pkg::ctrl_status_type status,
   input  logic [7:0]              payload_byte,
   input  logic                    has_byte,
   input  logic [15:0]             at_command,
   input  logic [63:0]             dest_mac,
   output logic [7:0]              frame_byte,
   output logic                    frame_end,
   output logic                    overflow
);
   import rcfb_pkg::*;

   localparam int CNT_W  = $clog2(MAX_PAYLOAD + 1);
   localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int POS_W  = $clog2(MAX_PAYLOAD + HDR_BYTES + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PAYLOAD);

   logic [CNT_W-1:0]  count_ff, count_in;
   logic              drop_ff, drop_in;
   logic [15:0]       cmd_ff;
   logic [63:0]       mac_ff;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [7:0]        sum_ff, sum_in;
   logic [7:0]        byte_ff;
   logic              end_ff;
   logic              ovf_ff;

   logic              full;
   logic              store;
   logic              is_chk;
   logic [15:0]       frame_len;
   logic [POS_W-1:0]  count_pos;
   logic [POS_W-1:0]  rd_idx;
   logic              rd_en;
   logic [7:0]        rd_data;
   logic [2:0]        mac_sel;
   logic [7:0]        mac_bytes [8];
   logic [7:0]        next_byte;

   assign full      = (count_ff == CNT_MAX);
   assign store     = cmd.accept && has_byte && !full;
   assign count_pos = POS_W'(count_ff);
   assign is_chk    = (pos_ff == count_pos + POS_W'(HDR_BYTES));
   assign frame_len = BASE_LEN + 16'(count_ff);
   assign status.last_byte = is_chk;

   // prefetch: read the payload byte for the position after the one loaded
   assign rd_idx = pos_ff - POS_W'(POS_CMD_LO);
   assign rd_en  = cmd.load && (pos_ff >= POS_W'(POS_CMD_LO)) && (rd_idx < count_pos);

   rcfb_ram #(
      .WIDTH (8),
      .DEPTH (MAX_PAYLOAD)
   ) u_store (
      .clock   (clock),
      .wr_en   (store),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (payload_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_idx[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign mac_sel = 3'(pos_ff - POS_W'(POS_MAC0));

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         mac_bytes[i] = mac_ff[63 - 8*i -: 8];
      end
   end

   always_comb begin
      next_byte = rd_data;
      if (is_chk) begin
         next_byte = ~sum_ff;
      end else if (pos_ff < POS_W'(HDR_BYTES)) begin
         unique case (pos_ff)
            POS_W'(POS_START):  next_byte = START_DELIM;
            POS_W'(POS_LEN_HI): next_byte = frame_len[15:8];
            POS_W'(POS_LEN_LO): next_byte = frame_len[7:0];
            POS_W'(POS_TYPE):   next_byte = FRAME_TYPE;
            POS_W'(POS_ID):     next_byte = FRAME_ID;
            POS_W'(POS_BC_HI):  next_byte = BCAST_HI;
            POS_W'(POS_BC_LO):  next_byte = BCAST_LO;
            POS_W'(POS_OPT):    next_byte = CMD_OPTIONS;
            POS_W'(POS_CMD_HI): next_byte = cmd_ff[15:8];
            POS_W'(POS_CMD_LO): next_byte = cmd_ff[7:0];
            default:            next_byte = mac_bytes[mac_sel];
         endcase
      end
   end

   always_comb begin
      count_in = count_ff;
      drop_in  = drop_ff;
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      if (store) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.accept && has_byte && full) begin
         drop_in = 1'b1;
      end
      if (cmd.start) begin
         pos_in = '0;
         sum_in = '0;
      end
      if (cmd.load) begin
         if (is_chk) begin
            count_in = '0;
            drop_in  = 1'b0;
            pos_in   = '0;
         end else begin
            pos_in = pos_ff + POS_W'(1);
            if (pos_ff >= POS_W'(POS_TYPE)) begin
               sum_in = sum_ff + next_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         drop_ff  <= 1'b0;
         pos_ff   <= '0;
      end else begin
         count_ff <= count_in;
         drop_ff  <= drop_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      if (cmd.start) begin
         cmd_ff <= at_command;
         mac_ff <= dest_mac;
      end
      if (cmd.load) begin
         byte_ff <= next_byte;
         end_ff  <= is_chk;
         ovf_ff  <= drop_ff;
      end
   end

   assign frame_byte = byte_ff;
   assign frame_end  = end_ff;
   assign overflow   = ovf_ff;

endmodule

// File: sv/rcfb_ctrl.sv
// ----------------------------------------------------------------------------
// rcfb_ctrl
// Controller: collect / emit sequencing and output word valid.
// ----------------------------------------------------------------------------
module rcfb_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_last,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rcfb_pkg::ctrl_cmd_type    cmd,
   input  rcfb_pkg::ctrl_status_type status
);
   import rcfb_pkg::*;

   typedef enum logic {
      ST_COLLECT,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;

   assign req_ready  = (state_ff == ST_COLLECT);
   assign cmd.accept = req_valid && req_ready;
   assign cmd.start  = cmd.accept && req_last;
   assign cmd.load   = (state_ff == ST_EMIT) && (!out_valid_ff || rsp_ready);
   assign rsp_valid  = out_valid_ff;

   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.load) begin
         out_valid_in = 1'b1;
      end
      unique case (state_ff)
         ST_COLLECT: begin
            if (cmd.start) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (cmd.load && status.last_byte) begin
               state_in = ST_COLLECT;
            end
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// File: sv/remote_command_frame_builder.sv
// ----------------------------------------------------------------------------
// remote_command_frame_builder
// Buffers payload bytes and emits a remote command request API frame.
// ----------------------------------------------------------------------------
// Payload words are taken one per cycle while collecting and their bytes
// written to a MAX_PAYLOAD-entry buffer RAM; bytes past capacity are dropped
// and flag overflow on every byte of that frame. The word marked last (which
// may also carry a byte) samples the command and destination address and
// starts emission: 19 + N frame bytes (N = stored payload bytes) leave at
// one byte per cycle while the output is ready, paced by a single output
// register with the next payload byte prefetched from the RAM read port.
// Input is held off from the last word until the checksum byte is loaded
// into the output register. No clearing pass is needed after reset.
module remote_command_frame_builder #(
   parameter int MAX_PAYLOAD = rcfb_pkg::MAX_PAYLOAD_DEF
) (
   input logic        clock,
   input logic        reset,
   rcfb_req_if.sink   req_chan,
   rcfb_rsp_if.source rsp_chan
);
   import rcfb_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   rcfb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   rcfb_dp #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .payload_byte (req_chan.payload_byte),
      .has_byte     (req_chan.has_byte),
      .at_command   (req_chan.at_command),
      .dest_mac     (req_chan.dest_mac),
      .frame_byte   (rsp_chan.frame_byte),
      .frame_end    (rsp_chan.frame_end),
      .overflow     (rsp_chan.overflow)
   );

`ifndef SYNTHESIS
   // a frame is at least 19 bytes, so input is always held off after last
   a_hold_after_last: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.last) |=> !req_chan.ready)
      else $error("input accepted right after last word");

   // overflow is constant across the bytes of one frame
   a_ovf_steady: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !rsp_chan.frame_end) |=>
      (!rsp_chan.valid || (rsp_chan.overflow == $past(rsp_chan.overflow))))
      else $error("overflow changed inside a frame");

   // frame bytes only come out after a last word starts emission
   a_load_in_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !req_chan.ready)
      else $error("frame byte loaded while collecting");
`endif

endmodule

// File: dv/tb_remote_command_frame_builder.sv
// ----------------------------------------------------------------------------
// tb_remote_command_frame_builder
// Drives payload words through the frame builder and compares every emitted
// frame byte against a byte-level frame predictor; random idle bursts on both
// channels, directed edge frames first, then random frames incl. overflow.
// ----------------------------------------------------------------------------
module tb_remote_command_frame_builder;
   timeunit 1ns;
   timeprecision 1ps;

   import rcfb_pkg::*;

   localparam int PAYLOAD_CAP = MAX_PAYLOAD_DEF;
   localparam int RANDOM_ITEMS = 160;
   localparam int DRAIN_LIMIT = 20000;
   localparam int TAIL_CYCLES = 20;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_end;
      logic       overflow;
   } frame_byte_type;

   class frame_scoreboard;
      logic [7:0]     stored [PAYLOAD_CAP];
      int unsigned    held;
      bit             dropped;
      frame_byte_type expected_bytes [$];
      int             errors;

      function new();
         held    = 0;
         dropped = 0;
         errors  = 0;
      endfunction

      // builds the whole expected frame when the last word is taken
      function void note_word(input logic [7:0] b, input logic hb, input logic lst,
                              input logic [15:0] cmd, input logic [63:0] mac);
         logic [7:0]  hdr [HDR_BYTES];
         logic [7:0]  sum;
         logic [15:0] len;
         logic        ovf;
         if (hb) begin
            if (held < PAYLOAD_CAP) begin
               stored[held] = b;
               held++;
            end else begin
               dropped = 1'b1;
            end
         end
         if (!lst) return;
         len = BASE_LEN + 16'(held);
         hdr[POS_START]  = START_DELIM;
         hdr[POS_LEN_HI] = len[15:8];
         hdr[POS_LEN_LO] = len[7:0];
         hdr[POS_TYPE]   = FRAME_TYPE;
         hdr[POS_ID]     = FRAME_ID;
         for (int k = 0; k < 8; k++)
            hdr[POS_MAC0 + k] = mac[63 - 8*k -: 8];
         hdr[POS_BC_HI]  = BCAST_HI;
         hdr[POS_BC_LO]  = BCAST_LO;
         hdr[POS_OPT]    = CMD_OPTIONS;
         hdr[POS_CMD_HI] = cmd[15:8];
         hdr[POS_CMD_LO] = cmd[7:0];
         ovf = dropped;
         sum = 8'h00;
         for (int k = 0; k < HDR_BYTES; k++) begin
            if (k >= POS_TYPE) sum = sum + hdr[k];
            expected_bytes.push_back('{hdr[k], 1'b0, ovf});
         end
         for (int k = 0; k < held; k++) begin
            sum = sum + stored[k];
            expected_bytes.push_back('{stored[k], 1'b0, ovf});
         end
         expected_bytes.push_back('{8'hFF - sum, 1'b1, ovf});
         held    = 0;
         dropped = 1'b0;
      endfunction

      task report_mismatch(input string msg);
         $display("%0t ns: MISMATCH %s", $realtime, msg);
         errors++;
      endtask

      task check_byte(input logic [7:0] b, input logic e, input logic o);
         frame_byte_type want;
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected frame byte %02h", b));
            return;
         end
         want = expected_bytes.pop_front();
         if (b !== want.frame_byte)
            report_mismatch($sformatf("frame_byte %02h, expected %02h", b, want.frame_byte));
         if (e !== want.frame_end)
            report_mismatch($sformatf("frame_end %b, expected %b (byte %02h)",
                                      e, want.frame_end, want.frame_byte));
         if (o !== want.overflow)
            report_mismatch($sformatf("overflow %b, expected %b (byte %02h)",
                                      o, want.overflow, want.frame_byte));
      endtask
   endclass

   logic clock;
   logic reset;

   rcfb_req_if req_if ();
   rcfb_rsp_if rsp_if ();

   remote_command_frame_builder i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if.sink),
      .rsp_chan (rsp_if.source)
   );

   frame_scoreboard sb = new();
   bit idle_on = 1'b1;
   int sent_items;

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // one word per call; valid stays high into the next call unless a gap is drawn
   task automatic send_word(input logic [7:0] b, input logic hb, input logic lst,
                            input logic [15:0] cmd, input logic [63:0] mac);
      req_if.valid        <= 1'b1;
      req_if.payload_byte <= b;
      req_if.has_byte     <= hb;
      req_if.last         <= lst;
      req_if.at_command   <= cmd;
      req_if.dest_mac     <= mac;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_word(b, hb, lst, cmd, mac);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic send_frame(input int nbytes, input bit byte_on_last, input bit noisy);
      logic [15:0] cmd;
      logic [63:0] mac;
      int          plain;
      cmd   = 16'($urandom_range(0, 65535));
      mac   = {$urandom, $urandom};
      plain = (byte_on_last && nbytes > 0) ? nbytes - 1 : nbytes;
      for (int k = 0; k < plain; k++) begin
         if (noisy && $urandom_range(0, 7) == 0)
            send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0,
                      16'($urandom_range(0, 65535)), {$urandom, $urandom});
         send_word(8'($urandom_range(0, 255)), 1'b1, 1'b0,
                   16'($urandom_range(0, 65535)), {$urandom, $urandom});
      end
      send_word(8'($urandom_range(0, 255)), byte_on_last && nbytes > 0, 1'b1, cmd, mac);
      sent_items += plain + 1;
   endtask

   task automatic wait_frames_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_bytes.size() != 0) @(posedge clock);
   endtask

   // result side: check on accept, then pick ready for the next edge
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_if.valid && rsp_if.ready)
               sb.check_byte(rsp_if.frame_byte, rsp_if.frame_end, rsp_if.overflow);
            if (stall_left > 0) begin
               rsp_if.ready <= 1'b0;
               stall_left--;
            end else begin
               rsp_if.ready <= 1'b1;
               if (idle_on && $urandom_range(0, 6) == 0)
                  stall_left = $urandom_range(1, 5);
            end
         end
      end
   end

   initial begin
      int n;
      int waited;
      bit paused_mid;
      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.payload_byte <= 8'h00;
      req_if.has_byte     <= 1'b0;
      req_if.last         <= 1'b0;
      req_if.at_command   <= 16'h0000;
      req_if.dest_mac     <= 64'h0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty payload, all-ones address and command
      send_word(8'h5A, 1'b0, 1'b1, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      // byte and last together, all-zero address and command
      send_word(8'hFF, 1'b1, 1'b1, 16'h0000, 64'h0);
      // byte extremes with a no-byte word in the middle
      send_word(8'h00, 1'b1, 1'b0, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_word(8'hFF, 1'b1, 1'b0, 16'h0000, 64'h0);
      send_word(8'hA5, 1'b0, 1'b0, 16'h1234, 64'h1);
      send_word(8'h80, 1'b1, 1'b0, 16'h5678, 64'h2);
      send_word(8'h3C, 1'b0, 1'b1, 16'h4944, 64'h0123_4567_89AB_CDEF);
      send_word(8'h01, 1'b1, 1'b0, 16'h0000, 64'h0);
      send_word(8'h7F, 1'b1, 1'b0, 16'h0000, 64'h0);
      send_word(8'hFE, 1'b1, 1'b1, 16'h8001, 64'h8000_0000_0000_0001);

      wait_frames_drained();

      sent_items = 0;
      paused_mid = 1'b0;
      // drops past capacity, then a buffer filled exactly by the last word
      send_frame(PAYLOAD_CAP + 3, 1'b1, 1'b1);
      send_frame(PAYLOAD_CAP, 1'b1, 1'b0);
      while (sent_items < RANDOM_ITEMS) begin
         if (sent_items >= RANDOM_ITEMS * 3 / 4) idle_on = 1'b0;
         case ($urandom_range(0, 9))
            0:       n = 0;
            1:       n = $urandom_range(PAYLOAD_CAP - 1, PAYLOAD_CAP + 3);
            default: n = $urandom_range(1, 8);
         endcase
         send_frame(n, $urandom_range(0, 1), 1'b1);
         if (!paused_mid && sent_items >= RANDOM_ITEMS / 2) begin
            paused_mid = 1'b1;
            wait_frames_drained();
         end
      end
      req_if.valid <= 1'b0;

      waited = 0;
      while (sb.expected_bytes.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.expected_bytes.size() != 0)
         sb.report_mismatch($sformatf("%0d frame bytes never arrived",
                                      sb.expected_bytes.size()));
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
